/* rtl/hash_sampled_trace_filter_unit_assert.svh */
// Assertion macros shared by the checker files of the trace filter.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef HASH_SAMPLED_TRACE_FILTER_UNIT_ASSERT_SVH
`define HASH_SAMPLED_TRACE_FILTER_UNIT_ASSERT_SVH

// Checked on every rising edge outside reset.
`define HSTF_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define HSTF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/hstf_pkg.sv */
// Package of the hash sampled trace filter: item and result types, constants, state codes.
// Depends on nothing; every other file of the block but the assertion header imports it.
`timescale 1ns / 1ps

package hstf_pkg;

    typedef struct packed {
        logic [31:0] thread_id;
        logic [31:0] relation_id;
        logic [31:0] block_number;
        logic [63:0] event_time;
        logic        access_hit;
        logic [63:0] meta_word;
    } item_t;

    typedef struct packed {
        logic [63:0]        page_key;
        logic [63:0]        event_time_out;
        logic [59:0]        policy_pointer;
        logic [31:0]        thread_id_out;
        logic signed [7:0]  policy_kind;
        logic               hit_flag;
    } result_t;

    // Register indexes of the configuration port.
    typedef enum logic [0:0] {
        CFG_SAMPLE_DIVISOR = 1'b0,
        CFG_END_TIME       = 1'b1
    } cfg_index_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_HOLD
    } back_state_t;

    localparam int unsigned DIVISOR_W = 31;

    localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
    localparam int unsigned FMIX_SHIFT = 33;

    localparam logic [63:0] META_LARGE = 64'd1000000000;

    // ceil(2^50 / 1e6); exact quotient by one million for any value below 2^30.
    localparam logic [30:0] KIND_RECIP       = 31'd1125899907;
    localparam int unsigned KIND_RECIP_SHIFT = 50;

    localparam logic [7:0]  KIND_NONE = 8'hff;

endpackage

/* rtl/hstf_front.sv */
// Front end of the trace filter: stop detection, page key forming and strategy decoding.
// Depends on hstf_pkg.
`timescale 1ns / 1ps

module hstf_front
    import hstf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  item_t       item,
    input  logic [63:0] end_time,
    output logic        enq,
    output result_t     entry
);

    logic        stopped_reg;
    logic        stopped_next;
    logic        late;
    logic        large_meta;
    logic [60:0] kind_prod;
    logic [7:0]  kind_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg <= 1'b0;
        end
        else
        begin
            stopped_reg <= stopped_next;
        end
    end

    always_comb
    begin
        late         = item.event_time > end_time;
        enq          = accept && !stopped_reg && !late;
        stopped_next = stopped_reg | (accept && late);
    end

    // Small metas hold the strategy type times one million.
    always_comb
    begin
        large_meta = item.meta_word > META_LARGE;
        kind_prod  = 61'(item.meta_word[29:0]) * 61'(KIND_RECIP);
        if (large_meta)
        begin
            kind_bits = {4'b0000, item.meta_word[3:0]} - 8'd1;
        end
        else if (item.meta_word != 64'd0)
        begin
            kind_bits = kind_prod[KIND_RECIP_SHIFT +: 8] - 8'd1;
        end
        else
        begin
            kind_bits = KIND_NONE;
        end
    end

    always_comb
    begin
        entry.page_key       = {item.relation_id, item.block_number};
        entry.event_time_out = item.event_time;
        entry.policy_pointer = large_meta ? item.meta_word[63:4] : 60'd0;
        entry.thread_id_out  = item.thread_id;
        entry.policy_kind    = kind_bits;
        entry.hit_flag       = item.access_hit;
    end

endmodule

/* rtl/hstf_queue.sv */
// Short queue of classified records between the front and back ends of the trace filter.
// Depends on hstf_pkg.
`timescale 1ns / 1ps

module hstf_queue
    import hstf_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    enq,
    input  result_t enq_data,
    input  logic    deq,
    output result_t head,
    output logic    full,
    output logic    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;

    always_comb
    begin
        full  = count_reg == CNT_W'(DEPTH);
        empty = count_reg == '0;
        head  = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slot_reg[wr_ptr_reg] <= enq_data;
        end
    end

endmodule

/* rtl/hstf_back.sv */
// Back end of the trace filter: fmix64 hash on one shared 32x32 multiplier, bit-serial
// remainder by the sample divisor, and the result register. Depends on hstf_pkg.
`timescale 1ns / 1ps

module hstf_back
    import hstf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  result_t              head,
    input  logic                 q_empty,
    output logic                 deq,
    input  logic [DIVISOR_W-1:0] sample_divisor,
    output result_t              result,
    output logic                 empty,
    input  logic                 pop
);

    back_state_t          state_reg, state_next;
    result_t              entry_reg, entry_next;
    result_t              out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic [63:0]          hv_reg, hv_next;
    logic [63:0]          acc_reg, acc_next;
    logic                 round_reg, round_next;
    logic [1:0]           mstep_reg, mstep_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [5:0]           bit_cnt_reg, bit_cnt_next;

    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic [63:0]          mul_c;
    logic [63:0]          product;
    logic [63:0]          mix_sum;
    logic [63:0]          mix_out;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   trial_sub;
    logic [DIVISOR_W-1:0] rem_step;
    logic                 sampling;
    logic                 load_out;

    // Low 64 bits of hv * C as three 32x32 partial products, one per cycle.
    always_comb
    begin
        mul_c   = round_reg ? FMIX_C2 : FMIX_C1;
        mul_a   = (mstep_reg == 2'd1) ? hv_reg[63:32] : hv_reg[31:0];
        mul_b   = (mstep_reg == 2'd2) ? mul_c[63:32] : mul_c[31:0];
        product = 64'(mul_a) * 64'(mul_b);
        mix_sum = acc_reg + {product[31:0], 32'd0};
        mix_out = mix_sum ^ (mix_sum >> FMIX_SHIFT);
    end

    always_comb
    begin
        trial     = {rem_reg, hv_reg[63]};
        trial_sub = trial - {1'b0, sample_divisor};
        rem_step  = (trial >= {1'b0, sample_divisor}) ? trial_sub[DIVISOR_W-1:0]
                                                      : trial[DIVISOR_W-1:0];
        sampling  = sample_divisor > DIVISOR_W'(1);
    end

    always_comb
    begin
        state_next   = state_reg;
        entry_next   = entry_reg;
        hv_next      = hv_reg;
        acc_next     = acc_reg;
        round_next   = round_reg;
        mstep_next   = mstep_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        deq          = 1'b0;
        load_out     = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    deq        = 1'b1;
                    entry_next = head;
                    hv_next    = head.page_key ^ (head.page_key >> FMIX_SHIFT);
                    round_next = 1'b0;
                    mstep_next = 2'd0;
                    state_next = sampling ? BK_MUL : BK_HOLD;
                end
            end
            BK_MUL:
            begin
                case (mstep_reg)
                    2'd0:
                    begin
                        acc_next   = product;
                        mstep_next = 2'd1;
                    end
                    2'd1:
                    begin
                        acc_next   = mix_sum;
                        mstep_next = 2'd2;
                    end
                    default:
                    begin
                        hv_next    = mix_out;
                        mstep_next = 2'd0;
                        if (round_reg)
                        begin
                            rem_next     = '0;
                            bit_cnt_next = 6'd63;
                            state_next   = BK_DIV;
                        end
                        else
                        begin
                            round_next = 1'b1;
                        end
                    end
                endcase
            end
            BK_DIV:
            begin
                rem_next     = rem_step;
                hv_next      = {hv_reg[62:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 6'd1;
                if (bit_cnt_reg == 6'd0)
                begin
                    state_next = (rem_step == '0) ? BK_HOLD : BK_IDLE;
                end
            end
            BK_HOLD:
            begin
                if (!out_valid_reg || pop)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_next = load_out ? entry_reg : out_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            round_reg     <= 1'b0;
            mstep_reg     <= 2'd0;
            bit_cnt_reg   <= 6'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            round_reg     <= round_next;
            mstep_reg     <= mstep_next;
            bit_cnt_reg   <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        out_reg   <= out_next;
        hv_reg    <= hv_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

endmodule

/* rtl/hash_sampled_trace_filter_unit.sv */
// Top level of the hash sampled trace filter: configuration registers and the three parts.
// Depends on hstf_pkg, hstf_front, hstf_queue and hstf_back.
`timescale 1ns / 1ps

// The filter takes one parsed buffer-access trace record per item and passes on, at most,
// one result item for it. An item whose timestamp lies beyond end_time closes the stream
// for good: it and every later item are accepted and dropped until reset. While the
// stream is open, a sample_divisor above 1 keeps a record only when the fmix64 hash of
// its page key leaves no remainder by the divisor; a divisor of 0 or 1 keeps every record.
// The front end classifies an item in the cycle it is accepted and places kept candidates
// in a short queue, so push is only held off while that queue is full. The back end takes
// one candidate at a time: with sampling on, it loads the candidate, runs the two 64-bit
// multiplies of the hash (one shared 32x32 multiplier, three partial products each),
// works out the bit-serial remainder and, for a kept record, loads the result register
// once it is free; with sampling off it loads the candidate and then the result register.
// Stopped items never enter the queue. With sampling on, the remainder loop sets the rate.
// Configuration writes are taken at any time but are meant to happen only while the
// block is idle.
module hash_sampled_trace_filter_unit
    import hstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input queue side.
    input  logic        push,
    output logic        full,
    input  item_t       item,
    // Result queue side.
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    // Configuration write port.
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [DIVISOR_W-1:0] sample_divisor_reg;
    logic [DIVISOR_W-1:0] sample_divisor_next;
    logic [63:0]          end_time_reg;
    logic [63:0]          end_time_next;

    logic    accept;
    logic    enq;
    logic    deq;
    logic    q_empty;
    result_t enq_data;
    result_t head;

    // Register writes complete in the cycle they are presented; there is no read-back.
    always_comb
    begin
        sample_divisor_next = sample_divisor_reg;
        end_time_next       = end_time_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SAMPLE_DIVISOR: sample_divisor_next = cfg_data[DIVISOR_W-1:0];
                CFG_END_TIME:       end_time_next       = cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_divisor_reg <= DIVISOR_W'(1);
            end_time_reg       <= '1;
        end
        else
        begin
            sample_divisor_reg <= sample_divisor_next;
            end_time_reg       <= end_time_next;
        end
    end

    // An item is taken whenever the candidate queue has room, dropped or not.
    assign accept = push && !full;

    hstf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .end_time (end_time_reg),
        .enq      (enq),
        .entry    (enq_data)
    );

    hstf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (enq),
        .enq_data (enq_data),
        .deq      (deq),
        .head     (head),
        .full     (full),
        .empty    (q_empty)
    );

    hstf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .q_empty        (q_empty),
        .deq            (deq),
        .sample_divisor (sample_divisor_reg),
        .result         (result),
        .empty          (empty),
        .pop            (pop)
    );

endmodule

/* rtl/hstf_checker.sv */
// Port-level checker of the trace filter and its bind to the top level.
// Depends on hstf_pkg and hash_sampled_trace_filter_unit_assert.svh.
`timescale 1ns / 1ps
`include "hash_sampled_trace_filter_unit_assert.svh"

module hstf_checker
    import hstf_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    full,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    // A waiting result item stays put until it is popped.
    `HSTF_ASSERT_RUN(a_result_holds, (!empty && !pop) |=> (!empty && $stable(result)), "result changed while waiting")

    // Once reset has been held across an edge, no result waits and there is room for input.
    `HSTF_ASSERT_ALWAYS(a_reset_clean, (!rst_n && $past(!rst_n)) |-> (empty && !full), "queue state wrong in reset")

    // A strategy pointer only comes from a meta word above one billion.
    `HSTF_ASSERT_RUN(a_pointer_range, (!empty && result.policy_pointer != 60'd0) |-> (result.policy_pointer >= 60'd62500000), "pointer from small meta word")

    // A result is only withdrawn by a pop.
    `HSTF_ASSERT_RUN(a_no_silent_drop, (!empty && !pop) |=> !empty, "result vanished without pop")

endmodule

bind hash_sampled_trace_filter_unit hstf_checker u_hstf_checker (.*);

/* test/tb.sv */
// Self-checking testbench of hash_sampled_trace_filter_unit: directed and random trace records.
// Depends on hstf_pkg and the RTL of the block; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module tb;
    import hstf_pkg::*;

    // Quiet cycles after the last expected result before the registers may change. The
    // queue holds two candidates and the back end one more, each going through the full
    // hash and remainder when sampling is on, and none of them may produce a result.
    localparam int SETTLE_CYCLES  = 400;
    // The receiver's deliberate hold-off; long enough for the block to fill up and
    // raise full while the sender keeps offering items.
    localparam int LONG_HOLD      = 500;
    // Cycles with no accepted item on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [63:0] ALL_ONES    = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] META_CUTOFF = 64'd1000000000;
    localparam logic [63:0] ONE_MILLION = 64'd1000000;
    localparam logic [63:0] MIX_MUL_A   = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_MUL_B   = 64'hc4ceb9fe1a85ec53;
    localparam logic [7:0]  NO_KIND     = 8'hff;
    localparam logic [30:0] DIVISOR_MAX = 31'h7fff_ffff;

    // Styles in which the receiver pops.
    typedef enum int {
        POP_ALWAYS,
        POP_HALF,
        POP_SPARSE,
        POP_CADENCE
    } pop_style_t;

    // The scoreboard holds its own copy of the registers and the stop flag, turns every
    // accepted record into the result it should produce, if any, and compares results in
    // arrival order against those expectations.
    class sampled_trace_scoreboard;
        logic [30:0] sample_divisor;
        logic [63:0] end_time;
        bit          stopped;
        result_t     kept_records[$];
        int          faults;

        function new();
            sample_divisor = 31'd1;
            end_time       = ALL_ONES;
            stopped        = 1'b0;
            faults         = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [63:0] value);
            case (idx)
                CFG_SAMPLE_DIVISOR: sample_divisor = value[30:0];
                CFG_END_TIME:       end_time = value;
            endcase
        endfunction

        // Murmur3 finalizer on the 64-bit page key.
        function logic [63:0] scramble_key(logic [63:0] v);
            v = v ^ (v >> 33);
            v = v * MIX_MUL_A;
            v = v ^ (v >> 33);
            v = v * MIX_MUL_B;
            v = v ^ (v >> 33);
            return v;
        endfunction

        function void predict_record(item_t rec);
            logic [63:0] key;
            logic [63:0] meta;
            logic [63:0] quotient;
            result_t     res;

            if (stopped)
                return;
            // The item that passes the end time closes the stream and is itself dropped.
            if (rec.event_time > end_time) begin
                stopped = 1'b1;
                return;
            end
            key = {rec.relation_id, rec.block_number};
            // A divisor of zero or one keeps everything.
            if (sample_divisor > 31'd1) begin
                if ((scramble_key(key) % {33'd0, sample_divisor}) != 64'd0)
                    return;
            end
            meta               = rec.meta_word;
            res.page_key       = key;
            res.event_time_out = rec.event_time;
            res.thread_id_out  = rec.thread_id;
            res.hit_flag       = rec.access_hit;
            res.policy_pointer = '0;
            res.policy_kind    = NO_KIND;
            if (meta > META_CUTOFF) begin
                // Large metas carry a pointer above a type nibble; nibble zero means none.
                res.policy_pointer = meta[63:4];
                res.policy_kind    = {4'd0, meta[3:0]} - 8'd1;
            end else if (meta != 64'd0) begin
                // Small metas hold the type times one million; only 8 bits survive.
                quotient        = meta / ONE_MILLION;
                res.policy_kind = quotient[7:0] - 8'd1;
            end
            kept_records.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t want;

            if (kept_records.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("tb: unexpected result key=%h time=%h ptr=%h tid=%h kind=%h hit=%b",
                             got.page_key, got.event_time_out, got.policy_pointer,
                             got.thread_id_out, got.policy_kind, got.hit_flag);
                return;
            end
            want = kept_records.pop_front();
            if (got.page_key !== want.page_key || got.event_time_out !== want.event_time_out ||
                got.policy_pointer !== want.policy_pointer ||
                got.thread_id_out !== want.thread_id_out ||
                got.policy_kind !== want.policy_kind || got.hit_flag !== want.hit_flag) begin
                faults++;
                if (faults <= 10) begin
                    $display("tb: mismatch expected key=%h time=%h ptr=%h tid=%h kind=%h hit=%b",
                             want.page_key, want.event_time_out, want.policy_pointer,
                             want.thread_id_out, want.policy_kind, want.hit_flag);
                    $display("tb:          actual   key=%h time=%h ptr=%h tid=%h kind=%h hit=%b",
                             got.page_key, got.event_time_out, got.policy_pointer,
                             got.thread_id_out, got.policy_kind, got.hit_flag);
                end
            end
        endfunction

        function int waiting();
            return kept_records.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    item_t       item      = '0;
    logic        empty;
    logic        pop       = 1'b0;
    result_t     result;
    logic        cfg_write = 1'b0;
    logic [0:0]  cfg_index = CFG_SAMPLE_DIVISOR;
    logic [63:0] cfg_data  = '0;

    sampled_trace_scoreboard trace_sb;
    item_t       record_q[$];
    bit          hold_request = 1'b0;
    int          hold_left    = 0;
    int          style_left   = 0;
    int          cadence      = 0;
    pop_style_t  pop_style    = POP_ALWAYS;
    int          quiet_cycles = 0;

    hash_sampled_trace_filter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Both handshakes are sampled here, on the values that stood before the edge, which is
    // what the block itself sees. The watchdog counts edges at which nothing moved.
    always @(posedge clk) begin
        if (rst_n) begin
            if (push && !full)
                trace_sb.predict_record(item);
            if (pop && !empty)
                trace_sb.check_result(result);
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    always @(posedge clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // The receiver switches between popping styles at random intervals. On request it
    // holds off completely for a long stretch so that the block backs up into full.
    always @(posedge clk) begin
        cadence++;
        if (!rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD - 1;
            pop <= 1'b0;
        end else begin
            if (style_left == 0) begin
                pop_style  = pop_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(40, 400);
            end else begin
                style_left--;
            end
            case (pop_style)
                POP_ALWAYS:  pop <= 1'b1;
                POP_HALF:    pop <= 1'($urandom_range(0, 1));
                POP_SPARSE:  pop <= ($urandom_range(0, 3) == 0);
                POP_CADENCE: pop <= ((cadence % 7) < 4);
            endcase
        end
    end

    function automatic item_t make_record(logic [31:0] tid, logic [31:0] rel, logic [31:0] blk,
                                          logic [63:0] stamp, logic hit, logic [63:0] meta);
        item_t rec;

        rec.thread_id    = tid;
        rec.relation_id  = rel;
        rec.block_number = blk;
        rec.event_time   = stamp;
        rec.access_hit   = hit;
        rec.meta_word    = meta;
        return rec;
    endfunction

    // Key halves are mostly random, with the extremes now and then.
    function automatic logic [31:0] pick_key_half();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Spread the meta word over every decoding branch: none, below one million, a scaled
    // type (exact multiples included), and large pointer words.
    function automatic logic [63:0] pick_meta();
        case ($urandom_range(0, 6))
            0:       return 64'd0;
            1:       return 64'($urandom_range(1, 999999));
            2:       return 64'($urandom_range(1000000, 1000000000));
            3:       return 64'($urandom_range(1, 1000)) * ONE_MILLION;
            4:       return {32'd0, $urandom} | 64'h1_0000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic item_t random_record(logic [63:0] time_cap);
        logic [63:0] stamp;

        stamp = {$urandom, $urandom};
        if (time_cap != ALL_ONES)
            stamp = stamp % (time_cap + 64'd1);
        return make_record($urandom, pick_key_half(), pick_key_half(), stamp,
                           1'($urandom_range(0, 1)), pick_meta());
    endfunction

    // Offers the queued records in bursts of random length with random gaps between them.
    // A third of the gaps are empty, so some stretches run back to back.
    task automatic send_records();
        int burst;
        int gap;

        while (record_q.size() > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && record_q.size() > 0) begin
                push <= 1'b1;
                item <= record_q.pop_front();
                @(posedge clk);
                while (full)
                    @(posedge clk);
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0 || record_q.size() == 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Waits until every expected result has been taken, then lets the block finish any
    // candidate that the sampler will still throw away.
    task automatic settle();
        @(posedge clk);
        while (trace_sb.waiting() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        trace_sb.write_reg(idx, value);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(int count, logic [63:0] time_cap);
        repeat (count) record_q.push_back(random_record(time_cap));
        send_records();
        settle();
    endtask

    initial begin
        logic [63:0] cutoff;

        trace_sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed records under the reset settings: field extremes, a timestamp equal
        // to the end time, and every way the meta word decodes, including a large word
        // whose type nibble is zero, metas below one million, the exact cutoff of one
        // billion, and type values that wrap in 8 bits.
        record_q.push_back(make_record(32'h0, 32'h0, 32'h0, 64'h0, 1'b0, 64'd0));
        record_q.push_back(make_record(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, ALL_ONES,
                                       1'b1, ALL_ONES));
        record_q.push_back(make_record(32'h1, 32'h0, 32'hffff_ffff, 64'd5, 1'b1, 64'd1));
        record_q.push_back(make_record(32'h2, 32'hffff_ffff, 32'h0, 64'd6, 1'b0, 64'd999999));
        record_q.push_back(make_record(32'h3, 32'h1, 32'h1, 64'd7, 1'b1, 64'd1000000));
        record_q.push_back(make_record(32'h4, 32'h2, 32'h2, 64'd8, 1'b0, 64'd1000000000));
        record_q.push_back(make_record(32'h5, 32'h3, 32'h3, 64'd9, 1'b1, 64'd1000000001));
        record_q.push_back(make_record(32'h6, 32'h4, 32'h4, 64'd10, 1'b0,
                                       64'h0123_4567_89ab_cde0));
        record_q.push_back(make_record(32'h7, 32'h5, 32'h5, 64'd11, 1'b1, 64'd300000000));
        record_q.push_back(make_record(32'h8, 32'h6, 32'h6, 64'd12, 1'b0, 64'd257000000));
        record_q.push_back(make_record(32'h9, 32'h7, 32'h7, 64'd13, 1'b1, 64'd256999999));
        record_q.push_back(make_record(32'ha, 32'h8, 32'h8, 64'd14, 1'b0, 64'd128000000));
        record_q.push_back(make_record(32'hb, 32'h9, 32'h9, 64'd15, 1'b1, 64'd129000000));
        record_q.push_back(make_record(32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
                                       64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'h5555_5555_5555_5555));
        record_q.push_back(make_record(32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa,
                                       64'h5555_5555_5555_5555, 1'b1, 64'haaaa_aaaa_aaaa_aaaa));
        send_records();
        settle();

        // Sampling off, written explicitly. The receiver stops for a long stretch while the
        // sender keeps going, which backs the block up until full is raised.
        write_reg(CFG_SAMPLE_DIVISOR, 64'd1);
        write_reg(CFG_END_TIME, ALL_ONES);
        hold_request = 1'b1;
        run_random(250, ALL_ONES);

        // A divisor of zero behaves like one.
        write_reg(CFG_SAMPLE_DIVISOR, 64'd0);
        run_random(150, ALL_ONES);

        // Sampling on with several divisors; each record now takes the slow path.
        write_reg(CFG_SAMPLE_DIVISOR, 64'd2);
        run_random(250, ALL_ONES);
        write_reg(CFG_SAMPLE_DIVISOR, 64'd3);
        run_random(200, ALL_ONES);
        write_reg(CFG_SAMPLE_DIVISOR, 64'd7);
        run_random(150, ALL_ONES);
        write_reg(CFG_SAMPLE_DIVISOR, 64'($urandom_range(4, 40)));
        run_random(150, ALL_ONES);
        // The largest divisor keeps next to nothing, so only a handful of records go here.
        write_reg(CFG_SAMPLE_DIVISOR, {33'd0, DIVISOR_MAX});
        run_random(10, ALL_ONES);

        // A random end time with every timestamp at or below it, one of them exactly on it.
        cutoff = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
        write_reg(CFG_SAMPLE_DIVISOR, 64'd2);
        write_reg(CFG_END_TIME, cutoff);
        record_q.push_back(make_record($urandom, $urandom, $urandom, cutoff, 1'b1, pick_meta()));
        run_random(150, cutoff);

        // End time zero: records stamped zero pass, the first later one closes the stream,
        // and nothing gets through afterwards, not even once the end time is raised again.
        write_reg(CFG_SAMPLE_DIVISOR, 64'd1);
        write_reg(CFG_END_TIME, 64'd0);
        repeat (10) record_q.push_back(random_record(64'd0));
        record_q.push_back(make_record($urandom, $urandom, $urandom, 64'd1, 1'b1, pick_meta()));
        run_random(20, ALL_ONES);
        write_reg(CFG_END_TIME, ALL_ONES);
        write_reg(CFG_SAMPLE_DIVISOR, 64'd3);
        run_random(20, ALL_ONES);

        if (trace_sb.faults == 0 && trace_sb.waiting() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
